FILE: src/kh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_pkg
// Shared types and constants of the k-mer histogram counter.
// ----------------------------------------------------------------------------
`default_nettype none

package kh_pkg;

    localparam int          SYM_W      = 8;
    localparam int          QIDX_W     = 12;
    localparam int          CNT_W      = 32;
    localparam int          KLEN_W     = 3;

    localparam logic [KLEN_W-1:0] KLEN_MIN   = 3'd2;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd2;

    localparam logic [CNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;

    // action codes
    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // character codes
    localparam logic [SYM_W-1:0] SYM_A  = 8'h41;
    localparam logic [SYM_W-1:0] SYM_C  = 8'h43;
    localparam logic [SYM_W-1:0] SYM_G  = 8'h47;
    localparam logic [SYM_W-1:0] SYM_T  = 8'h54;
    localparam logic [SYM_W-1:0] SYM_LF = 8'h0A;

    // base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // one histogram access; the address travels beside it
    typedef struct packed {
        logic              vld;
        logic              query;
        logic              zero;    // query index at or beyond 4^k
        logic [QIDX_W-1:0] qidx;
    } t_kh_op;

endpackage

`default_nettype wire

FILE: src/kh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_if
// Valid/ready channels of the k-mer histogram counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface kh_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  symbol;
    logic [11:0] kmer_index;

    modport source (output valid, action, symbol, kmer_index, input ready);
    modport sink   (input valid, action, symbol, kmer_index, output ready);
endinterface

interface kh_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] queried_index;
    logic [31:0] kmer_count;

    modport source (output valid, queried_index, kmer_count, input ready);
    modport sink   (input valid, queried_index, kmer_count, output ready);
endinterface

interface kh_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/kh_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_window
// Base decode, rolling k-mer window and k-mer length register.
// ----------------------------------------------------------------------------
`default_nettype none

module kh_window
    import kh_pkg::*;
#(
    parameter int MAX_K = 6,
    localparam int AW   = 2 * MAX_K
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [KLEN_W-1:0] i_cfg_data,
    input  wire logic              i_acc,
    input  wire logic              i_action,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire logic [QIDX_W-1:0] i_kmer_index,
    output t_kh_op                 o_op,
    output logic [AW-1:0]          o_addr
);

    logic [KLEN_W-1:0]      r_kmer_len;
    logic [AW-1:0]          r_window, n_window;
    logic [KLEN_W-1:0]      r_run, n_run;
    logic [KLEN_W-1:0]      k_eff;
    logic [KLEN_W:0]        shamt;
    logic [AW-1:0]          mask;
    logic                   is_base;
    logic [1:0]             code;
    logic [QIDX_W+3:0]      q_ext;
    logic [AW+QIDX_W-1:0]   q_wide;
    logic                   hit;

    always_comb begin
        k_eff = r_kmer_len;
        if (r_kmer_len < KLEN_MIN) begin
            k_eff = KLEN_MIN;
        end else if (int'(r_kmer_len) > MAX_K) begin
            k_eff = KLEN_W'(MAX_K);
        end
    end

    assign shamt = {k_eff, 1'b0};
    assign mask  = ~({AW{1'b1}} << shamt);

    always_comb begin
        is_base = 1'b1;
        code    = BASE_A;
        case (i_symbol)
            SYM_A:   code = BASE_A;
            SYM_C:   code = BASE_C;
            SYM_G:   code = BASE_G;
            SYM_T:   code = BASE_T;
            default: is_base = 1'b0;
        endcase
    end

    assign n_window = ((r_window << 2) | AW'(code)) & mask;
    assign n_run    = (r_run < k_eff) ? r_run + 1'b1 : r_run;
    assign hit      = (n_run >= k_eff);

    // query bounds and table address
    assign q_ext  = {4'b0, i_kmer_index};
    assign q_wide = {{AW{1'b0}}, i_kmer_index};

    always_comb begin
        o_op.vld   = i_acc && ((i_action == ACT_QUERY) || (is_base && hit));
        o_op.query = (i_action == ACT_QUERY);
        o_op.zero  = ((q_ext >> shamt) != '0);
        o_op.qidx  = i_kmer_index;
        o_addr     = (i_action == ACT_QUERY) ? q_wide[AW-1:0] : n_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= KLEN_RESET;
            r_window   <= '0;
            r_run      <= '0;
        end else if (i_cfg_we) begin
            r_kmer_len <= i_cfg_data;
            r_window   <= '0;
            r_run      <= '0;
        end else if (i_acc && (i_action == ACT_FEED) && (i_symbol != SYM_LF)) begin
            if (is_base) begin
                r_window <= n_window;
                r_run    <= n_run;
            end else begin
                r_window <= '0;
                r_run    <= '0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/kh_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_count_ram
// Count memory with read-modify-write, write forwarding and clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module kh_count_ram
    import kh_pkg::*;
#(
    parameter int MAX_K = 6,
    localparam int AW   = 2 * MAX_K,
    localparam int DEPTH = 1 << AW
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_kh_op           i_op,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic             i_hold,
    output logic                  o_clearing,
    output t_kh_op                o_s1,
    output logic [CNT_W-1:0]      o_count
);

    logic [CNT_W-1:0] mem [DEPTH];

    logic             r_clearing;
    logic [AW-1:0]    r_clr_addr;
    t_kh_op           r_s1;
    logic [AW-1:0]    r_s1_addr;
    logic [CNT_W-1:0] r_rd;
    logic             r_wr_vld;
    logic [AW-1:0]    r_wr_addr;
    logic [CNT_W-1:0] r_wr_data;

    logic             s1_feed;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] inc;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [CNT_W-1:0] wdata;

    // read issued in the cycle of a write to the same bin sees old data
    assign cur     = (r_wr_vld && (r_wr_addr == r_s1_addr)) ? r_wr_data : r_rd;
    assign inc     = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    assign s1_feed = r_s1.vld && !r_s1.query;

    assign we    = r_clearing || s1_feed;
    assign waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign wdata = r_clearing ? '0 : inc;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_op.vld) begin
            r_rd <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_wr_vld <= 1'b0;
        end else if (!i_hold) begin
            r_s1     <= i_op;
            r_wr_vld <= s1_feed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_hold) begin
            r_s1_addr <= i_addr;
            r_wr_addr <= r_s1_addr;
            r_wr_data <= inc;
        end
    end

    assign o_clearing = r_clearing;
    assign o_s1       = r_s1;
    assign o_count    = r_s1.zero ? '0 : cur;

endmodule

`default_nettype wire

FILE: src/kmer_histogram_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_histogram_counter
// DNA k-mer histogram over a character stream, with count queries.
// ----------------------------------------------------------------------------
// Usage:
//   i_item  : input words. action 0 feeds one character (symbol), action 1
//             queries the count of kmer_index (base-4, first base in the MSBs).
//   o_result: one word per query: queried_index and its saturating count,
//             zero when the index is at or beyond 4^k. Feeds give no word.
//   i_cfg   : k-mer length k (2..MAX_K, clamped). A write restarts the
//             window; counts are kept. Always ready.
// Throughput: one input word per cycle while ready is high. Every feed that
//   closes a window does one read-modify-write of its bin: read at
//   acceptance, written back in the next cycle; a back-to-back hit on the
//   same bin is forwarded. A query is answered from the result register.
// Reset: the count memory is swept to zero, one bin a cycle, over all
//   4^MAX_K bins (4096 at MAX_K = 6); i_item.ready stays low meanwhile.
// Stall: the result register keeps its word until taken. Feeds keep
//   flowing; only a second query that reaches the read stage while the
//   result register is still full holds the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_histogram_counter
    import kh_pkg::*;
#(
    parameter int MAX_K = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kh_in_if.sink     i_item,
    kh_cfg_if.sink    i_cfg,
    kh_out_if.source  o_result
);

    localparam int AW = 2 * MAX_K;

    t_kh_op            op;
    logic [AW-1:0]     op_addr;
    t_kh_op            s1;
    logic [CNT_W-1:0]  s1_count;
    logic              clearing;
    logic              acc;
    logic              out_free;
    logic              hold;

    logic              r_out_vld;
    logic [QIDX_W-1:0] r_out_idx;
    logic [CNT_W-1:0]  r_out_cnt;

    // a query in the read stage waits while the result register is full
    assign out_free = !r_out_vld || o_result.ready;
    assign hold     = s1.vld && s1.query && !out_free;

    assign i_item.ready = !clearing && !hold;
    assign acc          = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    kh_window #(
        .MAX_K (MAX_K)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_acc        (acc),
        .i_action     (i_item.action),
        .i_symbol     (i_item.symbol),
        .i_kmer_index (i_item.kmer_index),
        .o_op         (op),
        .o_addr       (op_addr)
    );

    kh_count_ram #(
        .MAX_K (MAX_K)
    ) u_count_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_addr     (op_addr),
        .i_hold     (hold),
        .o_clearing (clearing),
        .o_s1       (s1),
        .o_count    (s1_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1.vld && s1.query && !hold) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1.vld && s1.query && !hold) begin
            r_out_idx <= s1.qidx;
            r_out_cnt <= s1_count;
        end
    end

    assign o_result.valid         = r_out_vld;
    assign o_result.queried_index = r_out_idx;
    assign o_result.kmer_count    = r_out_cnt;

    // a held query stays in the read stage unchanged
    a_hold_keeps_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |=> (s1.vld && s1.query && $stable(s1.qidx)))
        else $error("held query lost from read stage");

    // nothing is read or written back while the clear pass runs
    a_no_access_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!op.vld && !s1.vld))
        else $error("histogram access during clear pass");

    // an out-of-range query always reports zero
    a_zero_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1.vld && s1.query && s1.zero && !hold) |=> (r_out_vld && r_out_cnt == '0))
        else $error("nonzero count for index beyond table span");

    // input is never taken while a held query blocks the read stage
    a_no_accept_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |-> !op.vld)
        else $error("new access issued while read stage is held");

endmodule

`default_nettype wire

FILE: tb/tb_kmer_histogram_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_histogram_counter
// Self-checking bench for the k-mer histogram counter: a short table of
// directed words, then phases of random character streams and count
// queries under every k-mer length, with random idling on both channels.
// Each query result is checked against an in-bench copy of the histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kmer_histogram_counter;
    import kh_pkg::*;

    localparam int MAX_K       = 6;
    localparam int BIN_COUNT   = 1 << (2 * MAX_K);
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;     // cycles for the bin write-back to land
    localparam int PHASE_ITEMS = 120;
    localparam int HOLD_CYCLES = 400;

    // bytes that are neither a base nor a line feed
    localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] SYM_CR      = 8'h0D;
    localparam logic [SYM_W-1:0] SYM_NUL     = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL1    = 8'hFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // one directed word; pinned rows carry a count read straight off the spec
    typedef struct packed {
        logic              act;
        logic [SYM_W-1:0]  sym;
        logic [QIDX_W-1:0] idx;
        logic              pinned;
        logic [CNT_W-1:0]  want;
    } t_dir_row;

    typedef struct {
        logic [QIDX_W-1:0] qidx;
        logic [CNT_W-1:0]  count;
    } t_count_word;

    localparam int DIR_N = 25;

    logic clk;
    logic rst_n;

    kh_in_if  in_ch ();
    kh_out_if out_ch ();
    kh_cfg_if cfg_ch ();

    kmer_histogram_counter #(
        .MAX_K (MAX_K)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (out_ch.source)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Histogram mirror: bins, rolling window, run length, k register
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  hist_bins [BIN_COUNT];
    logic [QIDX_W-1:0] win_code;
    logic [2:0]        base_run;
    logic [KLEN_W-1:0] klen_reg;

    t_count_word pending_counts [$];

    int fail_cnt;
    int n_feeds;
    int n_queries;
    int n_bumps;
    int n_cfg;
    int cycle_cnt;

    // pinned expectation travels beside the driven word
    logic             pin_vld;
    logic [CNT_W-1:0] pin_count;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_left;

    t_dir_row dir_rows [DIR_N];

    function automatic int eff_len(logic [KLEN_W-1:0] r);
        if (r < KLEN_MIN) return int'(KLEN_MIN);
        if (r > MAX_K)    return MAX_K;
        return int'(r);
    endfunction

    function automatic void load_length(logic [KLEN_W-1:0] v);
        klen_reg = v;
        win_code = '0;      // a new length restarts the window, bins stay
        base_run = '0;
    endfunction

    function automatic void absorb_symbol(logic [SYM_W-1:0] s);
        int                k;
        logic [QIDX_W-1:0] mask;
        logic [1:0]        b;
        k    = eff_len(klen_reg);
        mask = QIDX_W'((1 << (2 * k)) - 1);
        if (s == SYM_LF) return;            // lines join into one sequence
        case (s)
            SYM_A:   b = BASE_A;
            SYM_C:   b = BASE_C;
            SYM_G:   b = BASE_G;
            SYM_T:   b = BASE_T;
            default: begin
                win_code = '0;
                base_run = '0;
                return;
            end
        endcase
        win_code = {win_code[QIDX_W-3:0], b} & mask;
        if (base_run < k) base_run = base_run + 3'd1;
        if (base_run >= k && hist_bins[win_code] != COUNT_MAX) begin
            hist_bins[win_code] = hist_bins[win_code] + 1;
            n_bumps++;
        end
    endfunction

    function automatic logic [CNT_W-1:0] lookup_count(logic [QIDX_W-1:0] idx);
        int span;
        span = 1 << (2 * eff_len(klen_reg));
        return (int'(idx) < span) ? hist_bins[idx] : '0;
    endfunction

    task automatic report_mismatch(string what, logic [QIDX_W-1:0] idx,
                                   logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        $display("MISMATCH %s: index %0d got %0d want %0d", what, idx, got, want);
        fail_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_count_word head;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_counts.size() == 0) begin
                    report_mismatch("word with nothing pending", out_ch.queried_index,
                                    out_ch.kmer_count, '0);
                end else begin
                    head = pending_counts.pop_front();
                    if (out_ch.queried_index !== head.qidx)
                        report_mismatch("queried_index", head.qidx,
                                        CNT_W'(out_ch.queried_index), CNT_W'(head.qidx));
                    if (out_ch.kmer_count !== head.count)
                        report_mismatch("kmer_count", head.qidx,
                                        out_ch.kmer_count, head.count);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                load_length(cfg_ch.data);
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.action == ACT_QUERY) begin
                    head.qidx  = in_ch.kmer_index;
                    head.count = pin_vld ? pin_count : lookup_count(in_ch.kmer_index);
                    pending_counts.insert(pending_counts.size(), head);
                    n_queries++;
                end else begin
                    absorb_symbol(in_ch.symbol);
                    n_feeds++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (recv_stall_pct == 0) ||
                            ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_kmer_histogram_counter failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the word
    // was taken. valid stays high between back-to-back words.
    task automatic send_word(logic act, logic [SYM_W-1:0] sym, logic [QIDX_W-1:0] idx,
                             logic pinned, logic [CNT_W-1:0] want);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.symbol     <= sym;
        in_ch.kmer_index <= idx;
        pin_vld          <= pinned;
        pin_count        <= want;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // wait until every query has been answered, then let the last write land
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_length(logic [KLEN_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_idle(t_idle_mode m);
        case (m)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default:   begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // Random phase: mostly clean base runs so long windows complete, some
    // line feeds, some restarting bytes. Queries lean on the current window
    // so that nonzero bins get read back.
    task automatic run_phase(int n_items, int query_pct, int pause_at);
        int                span;
        int                pick;
        logic [SYM_W-1:0]  sym;
        logic [QIDX_W-1:0] idx;
        logic [1:0]        b;
        span = 1 << (2 * eff_len(klen_reg));
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) drain_results();
            sym = SYM_A;
            idx = '0;
            if ($urandom_range(0, 99) < query_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      idx = win_code;
                else if (pick < 70) idx = QIDX_W'($urandom_range(0, span - 1));
                else if (pick < 85) idx = QIDX_W'($urandom_range(0, BIN_COUNT - 1));
                else begin
                    case ($urandom_range(0, 2))
                        0:       idx = '0;
                        1:       idx = QIDX_W'(span - 1);
                        default: idx = QIDX_W'((span < BIN_COUNT) ? span : BIN_COUNT - 1);
                    endcase
                end
                send_word(ACT_QUERY, SYM_W'($urandom_range(0, 255)), idx, 1'b0, '0);
            end else begin
                pick = $urandom_range(0, 99);
                b    = 2'($urandom_range(0, 3));
                if (pick < 82) begin
                    case (b)
                        BASE_A:  sym = SYM_A;
                        BASE_C:  sym = SYM_C;
                        BASE_G:  sym = SYM_G;
                        default: sym = SYM_T;
                    endcase
                end else if (pick < 88) begin
                    sym = SYM_LF;
                end else if (pick < 94) begin
                    sym = (b == BASE_A) ? SYM_CR : SYM_W'(SYM_LOWER_A + b);
                end else begin
                    sym = SYM_W'($urandom_range(0, 255));
                end
                send_word(ACT_FEED, sym, QIDX_W'($urandom_range(0, BIN_COUNT - 1)),
                          1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [KLEN_W-1:0] phase_len [9];

        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_FEED;
        in_ch.symbol     = '0;
        in_ch.kmer_index = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        pin_vld          = 1'b0;
        pin_count        = '0;
        hold_req         = 0;
        hold_left        = 0;
        fail_cnt         = 0;
        n_feeds          = 0;
        n_queries        = 0;
        n_bumps          = 0;
        n_cfg            = 0;
        for (int i = 0; i < BIN_COUNT; i++) hist_bins[i] = '0;
        load_length(KLEN_RESET);
        set_idle(IDLE_NONE);

        // Directed table, run at the reset length of two. Counts of a fresh
        // histogram and of indexes at or past 4^k are pinned; the rest come from
        // the mirror.
        dir_rows = '{
            '{ACT_QUERY, SYM_NUL,     12'd0,                 1'b1, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'hFFF,               1'b1, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_T, BASE_T}), 1'b1, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'd16,                1'b1, 32'd0},
            '{ACT_FEED,  SYM_A,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_C,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_G,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_T,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_LF,      12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_A,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_LOWER_A, 12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_C,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_CR,      12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_G,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_G,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_NUL,     12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_ALL1,    12'hFFF,               1'b0, 32'd0},
            '{ACT_FEED,  SYM_T,       12'd0,                 1'b0, 32'd0},
            '{ACT_FEED,  SYM_T,       12'd0,                 1'b0, 32'd0},
            '{ACT_QUERY, SYM_ALL1,    12'({BASE_A, BASE_C}), 1'b0, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_T, BASE_A}), 1'b0, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_G, BASE_G}), 1'b0, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_T, BASE_T}), 1'b0, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_T, BASE_C}), 1'b0, 32'd0},
            '{ACT_QUERY, SYM_NUL,     12'({BASE_C, BASE_A}), 1'b0, 32'd0}
        };

        // lengths per phase: both ends of the legal range and the clamped codes
        phase_len = '{3'd6, 3'd3, 3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first word waits out the post-reset clearing sweep on ready
        for (int r = 0; r < DIR_N; r++)
            send_word(dir_rows[r].act, dir_rows[r].sym, dir_rows[r].idx,
                      dir_rows[r].pinned, dir_rows[r].want);

        for (int p = 0; p < 9; p++) begin
            drain_results();
            write_length(phase_len[p]);
            set_idle(t_idle_mode'(p % 4));
            run_phase(PHASE_ITEMS, 25, -1);
        end

        // Back-pressure: receiver holds off for a long stretch while queries
        // keep coming, so the result register fills and the input stalls.
        // Halfway through the sender stops until every answer is back.
        drain_results();
        write_length(3'd3);
        set_idle(IDLE_NONE);
        hold_req = HOLD_CYCLES;
        run_phase(60, 60, 30);

        drain_results();
        if (pending_counts.size() != 0)
            report_mismatch("answers never returned", '0, pending_counts.size(), '0);

        $display("Covered %0d feeds and %0d queries over %0d length writes;",
                 n_feeds, n_queries, n_cfg);
        $display("%0d bin increments mirrored, %0d mismatches.", n_bumps, fail_cnt);
        if (fail_cnt == 0) begin
            $display("tb_kmer_histogram_counter passed");
        end else begin
            $display("tb_kmer_histogram_counter failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
